// ===== rtl/core/gprd_pkg.sv =====
// Package for the controller report deframer: register reset values, byte
// offsets within a report, the result layout and small helper functions.
// No dependencies.
package gprd_pkg;

    localparam int unsigned REPORT_LEN = 9;
    localparam int unsigned STORE_LEN  = 8;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned OUT_W      = 64;

    localparam logic [7:0] HEADER_RESET   = 8'h88;
    localparam logic [6:0] DEADZONE_RESET = 7'd10;

    // Configuration register indexes.
    localparam logic REG_HEADER   = 1'b0;
    localparam logic REG_DEADZONE = 1'b1;

    // Input kinds carried on tuser.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_FAIL = 1'b1;

    // Byte offsets in the frame store.
    localparam int unsigned OFS_HEADER  = 0;
    localparam int unsigned OFS_LEFT_X  = 1;
    localparam int unsigned OFS_LEFT_Y  = 2;
    localparam int unsigned OFS_LTRIG   = 3;
    localparam int unsigned OFS_RTRIG   = 4;
    localparam int unsigned OFS_RIGHT_X = 5;
    localparam int unsigned OFS_RIGHT_Y = 6;
    localparam int unsigned OFS_BTN_LO  = 7;

    typedef struct packed {
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic [7:0]  left_trigger;
        logic [7:0]  right_trigger;
        logic [12:0] buttons;
        logic        link_ok;
        logic        header_matched;
    } t_report;

    // A stick value whose magnitude is not above the threshold reads as zero.
    function automatic logic [7:0] apply_deadzone(input logic [7:0] raw,
                                                  input logic [6:0] dz);
        logic [8:0] mag;
        begin
            mag = raw[7] ? (9'd256 - {1'b0, raw}) : {1'b0, raw};
            apply_deadzone = (mag > {2'b00, dz}) ? raw : 8'h00;
        end
    endfunction

    // Lowest field in the lowest bits, padded with zero to whole bytes.
    function automatic logic [OUT_W-1:0] pack_report(input t_report r);
        begin
            pack_report = {1'b0, r.header_matched, r.link_ok, r.buttons,
                           r.right_trigger, r.left_trigger, r.right_y,
                           r.right_x, r.left_y, r.left_x};
        end
    endfunction

endpackage

// ===== rtl/core/gamepad_report_deframer.sv =====
// Controller report deframer: collects nine report bytes, checks the header
// and delivers unpacked sticks, triggers and buttons through a two-entry
// output buffer. Depends on gprd_pkg.
//
// Channel  | Direction | Transaction moves
// s_axis   | in        | one received byte (tdata) or a bus failure (tuser)
// m_axis   | out       | one decoded report or failure result
// cfg      | in        | one register write: index 0 header, 1 deadzone
//
// One byte is accepted per cycle while the skid entry is empty; the result of the
// ninth byte or failure goes to the output register, or to the skid entry if the output stalls.
// The frame store and a single adder/compare per stick set the only path.
// Reset (synchronous, active low) clears the byte count, link flag, buffer
// and restores the register defaults; the frame store is not cleared.
// A stalled output fills the second buffer entry; input stalls only when
// both entries hold results.
module gamepad_report_deframer
    import gprd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
    input  logic             s_axis_tuser,   // [0] kind
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [7:0] left_x, [15:8] left_y, [23:16] right_x, [31:24] right_y,
    // [39:32] left_trigger, [47:40] right_trigger, [60:48] buttons,
    // [61] link_ok, [62] header_matched, [63] zero
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [7:0]       i_cfg_data
);

    logic [7:0]       r_header;
    logic [6:0]       r_deadzone;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_store [STORE_LEN];
    logic             r_link;
    logic             n_link;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out;
    logic             r_skid_valid;
    logic [OUT_W-1:0] r_skid;

    logic             in_fire;
    logic             frame_done;
    logic             new_res;
    t_report          res;
    logic             out_load;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign frame_done    = r_pos >= POS_W'(STORE_LEN);
    assign new_res       = in_fire && ((s_axis_tuser == KIND_FAIL) || frame_done);
    assign out_load      = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_comb begin
        res    = '0;
        n_pos  = r_pos;
        n_link = r_link;
        if (in_fire) begin
            if (s_axis_tuser == KIND_FAIL) begin
                n_pos  = '0;
                n_link = 1'b0;
            end else if (!frame_done) begin
                n_pos = r_pos + POS_W'(1);
            end else begin
                n_pos = '0;
                if (r_store[OFS_HEADER] == r_header) begin
                    n_link             = 1'b1;
                    res.left_x         = apply_deadzone(r_store[OFS_LEFT_X], r_deadzone);
                    res.left_y         = apply_deadzone(r_store[OFS_LEFT_Y], r_deadzone);
                    res.right_x        = apply_deadzone(r_store[OFS_RIGHT_X], r_deadzone);
                    res.right_y        = apply_deadzone(r_store[OFS_RIGHT_Y], r_deadzone);
                    res.left_trigger   = r_store[OFS_LTRIG];
                    res.right_trigger  = r_store[OFS_RTRIG];
                    // Buttons are unpacked most-significant bit first.
                    for (int i = 0; i < 8; i++) begin
                        res.buttons[i] = r_store[OFS_BTN_LO][7-i];
                    end
                    for (int j = 0; j < 5; j++) begin
                        res.buttons[8+j] = s_axis_tdata[4-j];
                    end
                    res.header_matched = 1'b1;
                end
            end
        end
        res.link_ok = n_link;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header   <= HEADER_RESET;
            r_deadzone <= DEADZONE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HEADER:   r_header   <= i_cfg_data;
                REG_DEADZONE: r_deadzone <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_link <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (s_axis_tuser == KIND_DATA) && !frame_done) begin
            r_store[r_pos[2:0]] <= s_axis_tdata;
        end
    end

    // Two-entry output buffer: the skid entry drains into the output register first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_load) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= new_res;
            end
        end else if (new_res) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_skid_valid ? r_skid : pack_report(res);
        end
        if (!out_load && new_res) begin
            r_skid <= pack_report(res);
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(STORE_LEN))
        else $error("byte count beyond the frame store");

    a_fail_clears_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tuser == KIND_FAIL) |=> (!r_link && r_pos == '0 && r_out_valid))
        else $error("bus failure did not clear the link and restart the frame");

    a_byte_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tuser == KIND_DATA && !frame_done)
            |=> (r_pos == $past(r_pos) + POS_W'(1)))
        else $error("stored byte did not advance the byte count");

endmodule
